[sv/rsq_pkg.sv]
// Shared types, constants and helper functions of the rotated sprite quad expansion unit.
`default_nettype none

package rsq_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_STAGES = 13;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POSITION_MODE     = 3'd0,
    REG_PREMULTIPLY_ALPHA = 3'd1,
    REG_ANCHOR_X          = 3'd2,
    REG_ANCHOR_Y          = 3'd3,
    REG_OFFSET_X          = 3'd4,
    REG_OFFSET_Y          = 3'd5,
    REG_MATRIX_ROW_A      = 3'd6,
    REG_MATRIX_ROW_B      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_RELATIVE = 2'd1,
    MODE_GROUPED  = 2'd2
  } pos_mode_t;

  // Angle reduction: integer degrees biased by a multiple of 360, reciprocal of 360.
  localparam int DEG_BIAS  = 33120;
  localparam int DEG_RECIP = 46604;
  localparam int DEG_SHIFT = 24;

  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

  // Reciprocals for the Taylor coefficient divides.
  localparam int DIV_SHIFT = 32;
  localparam logic [31:0] RECIP_42 = 32'((64'd1 << DIV_SHIFT) / 42);
  localparam logic [31:0] RECIP_56 = 32'((64'd1 << DIV_SHIFT) / 56);
  localparam logic [31:0] RECIP_20 = 32'((64'd1 << DIV_SHIFT) / 20);
  localparam logic [31:0] RECIP_30 = 32'((64'd1 << DIV_SHIFT) / 30);
  localparam logic [31:0] RECIP_6  = 32'((64'd1 << DIV_SHIFT) / 6);
  localparam logic [31:0] RECIP_12 = 32'((64'd1 << DIV_SHIFT) / 12);

  typedef struct packed {
    logic signed [31:0] birth_x;
    logic signed [31:0] birth_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] edge_size;
    logic signed [31:0] rotation_deg;
    logic        [16:0] red;
    logic        [16:0] green;
    logic        [16:0] blue;
    logic        [16:0] alpha;
    logic               last_particle;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] bl_x;
    logic signed [31:0] bl_y;
    logic signed [31:0] br_x;
    logic signed [31:0] br_y;
    logic signed [31:0] tl_x;
    logic signed [31:0] tl_y;
    logic signed [31:0] tr_x;
    logic signed [31:0] tr_y;
    logic        [31:0] color_rgba;
    logic               last_quad;
  } quad_t;

  typedef struct packed {
    logic        [1:0]  position_mode;
    logic               premultiply_alpha;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
  } cfg_t;

  typedef struct packed {
    logic signed [51:0] cx;
    logic signed [51:0] cy;
    logic        [30:0] edge_size;
    logic        [31:0] color_rgba;
    logic               last;
  } side_t;

  // Finish a reciprocal divide: the estimate is low by at most one.
  function automatic logic [29:0] div_fix(input logic [29:0] v, input logic [61:0] prod,
                                          input logic [6:0] d);
    logic [29:0] q;
    logic [36:0] qd;
    logic [30:0] r;
    q  = 30'(prod >> DIV_SHIFT);
    qd = 37'(q) * 37'(d);
    r  = 31'(37'(v) - qd);
    if (r >= 31'(d)) begin
      q = q + 30'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

[sv/rsq_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface rsq_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/rsq_pipe_ctrl.sv]
// Stage valid bits and per-stage load enables of the pipeline.
`default_nettype none

module rsq_pipe_ctrl
  import rsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output stage_vec_t en
);

  stage_vec_t valid;

  // a stage may load when the output drains or when it or any later stage holds a bubble
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      en[k] = out_ready || (((~valid) >> k) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[NUM_STAGES-1];

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    (valid != '1) |-> in_ready)
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> valid[0])
    else $error("accepted beat did not enter the first stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (valid[NUM_STAGES-2] && en[NUM_STAGES-1]) |=> out_valid)
    else $error("beat lost before the output stage");

endmodule

`default_nettype wire

[sv/rsq_center.sv]
// Center position and color byte stages, with delay of the side data to the corner stages.
`default_nettype none

module rsq_center
  import rsq_pkg::*;
(
  input  logic       clk,
  input  stage_vec_t en,
  input  particle_t  p,
  input  cfg_t       cfg,
  output side_t      side
);

  localparam int SIDE_FIRST = 3;
  localparam int SIDE_LAST  = 10;
  localparam logic signed [64:0] LX_ROUND = 65'sd1 <<< (FRAC_BITS - 2);

  function automatic logic [7:0] to_byte(input logic [33:0] m);
    logic [41:0] t;
    logic [9:0]  b;
    t = (42'(m) << 8) - 42'(m);
    b = 10'(t >> 32);
    return (b > 10'd255) ? 8'hFF : b[7:0];
  endfunction

  // stage 0
  logic signed [32:0] s0_dx, s0_dy;
  logic signed [31:0] s0_center_x, s0_center_y;
  logic        [30:0] s0_edge;
  logic        [16:0] s0_red, s0_green, s0_blue, s0_alpha;
  logic               s0_last;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dx       <= 33'(cfg.anchor_x) - 33'(p.birth_x);
      s0_dy       <= 33'(cfg.anchor_y) - 33'(p.birth_y);
      s0_center_x <= p.center_x;
      s0_center_y <= p.center_y;
      s0_edge     <= p.edge_size;
      s0_red      <= p.red;
      s0_green    <= p.green;
      s0_blue     <= p.blue;
      s0_alpha    <= p.alpha;
      s0_last     <= p.last_particle;
    end
  end

  // stage 1
  logic signed [64:0] s1_p00, s1_p01, s1_p10, s1_p11;
  logic signed [32:0] s1_dx, s1_dy;
  logic signed [31:0] s1_center_x, s1_center_y;
  logic        [30:0] s1_edge;
  logic        [33:0] s1_mr, s1_mg, s1_mb, s1_ma;
  logic               s1_last;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_p00      <= 65'(cfg.m00) * 65'(s0_dx);
      s1_p01      <= 65'(cfg.m01) * 65'(s0_dy);
      s1_p10      <= 65'(cfg.m10) * 65'(s0_dx);
      s1_p11      <= 65'(cfg.m11) * 65'(s0_dy);
      s1_dx       <= s0_dx;
      s1_dy       <= s0_dy;
      s1_center_x <= s0_center_x;
      s1_center_y <= s0_center_y;
      s1_edge     <= s0_edge;
      s1_mr       <= cfg.premultiply_alpha ? 34'(s0_red) * 34'(s0_alpha)
                                           : {1'b0, s0_red, 16'b0};
      s1_mg       <= cfg.premultiply_alpha ? 34'(s0_green) * 34'(s0_alpha)
                                           : {1'b0, s0_green, 16'b0};
      s1_mb       <= cfg.premultiply_alpha ? 34'(s0_blue) * 34'(s0_alpha)
                                           : {1'b0, s0_blue, 16'b0};
      s1_ma       <= {1'b0, s0_alpha, 16'b0};
      s1_last     <= s0_last;
    end
  end

  // stage 2
  logic signed [64:0] lx_sum, ly_sum, lx_full, ly_full;
  logic signed [49:0] lx_term, ly_term;
  logic signed [49:0] s2_lx, s2_ly;
  logic signed [31:0] s2_center_x, s2_center_y;
  logic        [30:0] s2_edge;
  logic        [31:0] s2_color;
  logic               s2_last;

  always_comb begin
    lx_sum  = (s1_p00 >>> 1) + (s1_p01 >>> 1);
    ly_sum  = (s1_p10 >>> 1) + (s1_p11 >>> 1);
    lx_full = (lx_sum + LX_ROUND) >>> (FRAC_BITS - 1);
    ly_full = (ly_sum + LX_ROUND) >>> (FRAC_BITS - 1);
    case (cfg.position_mode)
      MODE_FREE: begin
        lx_term = 50'(lx_full);
        ly_term = 50'(ly_full);
      end
      MODE_RELATIVE: begin
        lx_term = 50'(s1_dx);
        ly_term = 50'(s1_dy);
      end
      default: begin
        lx_term = '0;
        ly_term = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_lx       <= lx_term;
      s2_ly       <= ly_term;
      s2_center_x <= s1_center_x;
      s2_center_y <= s1_center_y;
      s2_edge     <= s1_edge;
      s2_color    <= {to_byte(s1_ma), to_byte(s1_mb), to_byte(s1_mg), to_byte(s1_mr)};
      s2_last     <= s1_last;
    end
  end

  // stage 3 onward: hold center and color beside the trig stages
  side_t side_q [SIDE_FIRST:SIDE_LAST];

  always_ff @(posedge clk) begin
    if (en[SIDE_FIRST]) begin
      side_q[SIDE_FIRST].cx         <= 52'(s2_center_x) - 52'(s2_lx) + 52'(cfg.offset_x);
      side_q[SIDE_FIRST].cy         <= 52'(s2_center_y) - 52'(s2_ly) + 52'(cfg.offset_y);
      side_q[SIDE_FIRST].edge_size  <= s2_edge;
      side_q[SIDE_FIRST].color_rgba <= s2_color;
      side_q[SIDE_FIRST].last       <= s2_last;
    end
    for (int k = SIDE_FIRST + 1; k <= SIDE_LAST; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side = side_q[SIDE_LAST];

endmodule

`default_nettype wire

[sv/rsq_sincos.sv]
// Angle reduction and fixed-point sine/cosine pipeline.
`default_nettype none

module rsq_sincos
  import rsq_pkg::*;
(
  input  logic               clk,
  input  stage_vec_t         en,
  input  logic signed [31:0] rotation_deg,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_neg_q
);

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } tag_t;

  // stage 0
  logic [16:0] dp;
  logic [16:0] s0_dp;
  logic [32:0] s0_mul;
  logic [FRAC_BITS-1:0] s0_frac;

  assign dp = 17'({rotation_deg[31], rotation_deg[31:FRAC_BITS]}) + 17'(DEG_BIAS);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dp   <= dp;
      s0_mul  <= 33'(dp) * 33'(DEG_RECIP);
      s0_frac <= rotation_deg[FRAC_BITS-1:0];
    end
  end

  // stage 1
  logic [7:0] qdeg;
  logic [8:0] s1_rdeg;
  logic [FRAC_BITS-1:0] s1_frac;

  assign qdeg = 8'(s0_mul >> DEG_SHIFT);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_rdeg <= 9'(s0_dp - 17'(qdeg) * 17'd360);
      s1_frac <= s0_frac;
    end
  end

  // stage 2
  logic [1:0]  quad;
  logic [8:0]  qbase;
  logic [6:0]  tdeg;
  logic [22:0] t_full;
  logic        swap;
  logic [21:0] t_red;
  logic [1:0]  s2_quad;
  logic        s2_swap;
  logic [46:0] s2_xprod;

  always_comb begin
    if (s1_rdeg < 9'd90) begin
      quad = 2'd0;
      qbase = 9'd0;
    end else if (s1_rdeg < 9'd180) begin
      quad = 2'd1;
      qbase = 9'd90;
    end else if (s1_rdeg < 9'd270) begin
      quad = 2'd2;
      qbase = 9'd180;
    end else begin
      quad = 2'd3;
      qbase = 9'd270;
    end
    tdeg   = 7'(s1_rdeg - qbase);
    t_full = 23'({tdeg, s1_frac});
    swap   = t_full > 23'(45 << FRAC_BITS);
    t_red  = 22'(swap ? 23'(90 << FRAC_BITS) - t_full : t_full);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_quad  <= quad;
      s2_swap  <= swap;
      s2_xprod <= 47'(t_red) * 47'(DEG_TO_RAD_Q30);
    end
  end

  // stages 3 to 9 carry quadrant, swap, x and x squared
  tag_t tag [3:9];
  logic [29:0] x;
  logic [59:0] s3_x2p;

  assign x = 30'(s2_xprod >> FRAC_BITS);

  logic [29:0] x2;
  logic [61:0] s4_pa, s4_pb;
  assign x2 = 30'(s3_x2p >> 30);

  logic [30:0] a1, b1;
  logic [60:0] s5_ma, s5_mb;
  assign a1 = Q30_ONE - 31'(div_fix(tag[4].x2, s4_pa, 7'd42));
  assign b1 = Q30_ONE - 31'(div_fix(tag[4].x2, s4_pb, 7'd56));

  logic [29:0] m5a, m5b;
  logic [29:0] s6_ma, s6_mb;
  logic [61:0] s6_pa, s6_pb;
  assign m5a = 30'(s5_ma >> 30);
  assign m5b = 30'(s5_mb >> 30);

  logic [30:0] a2, b2;
  logic [60:0] s7_ma, s7_mb;
  assign a2 = Q30_ONE - 31'(div_fix(s6_ma, s6_pa, 7'd20));
  assign b2 = Q30_ONE - 31'(div_fix(s6_mb, s6_pb, 7'd30));

  logic [29:0] m7a, m7b;
  logic [29:0] s8_ma, s8_mb;
  logic [61:0] s8_pa, s8_pb;
  assign m7a = 30'(s7_ma >> 30);
  assign m7b = 30'(s7_mb >> 30);

  logic [30:0] a3, b3;
  logic [60:0] s9_ma, s9_mb;
  assign a3 = Q30_ONE - 31'(div_fix(s8_ma, s8_pa, 7'd6));
  assign b3 = Q30_ONE - 31'(div_fix(s8_mb, s8_pb, 7'd12));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tag[3].quad <= s2_quad;
      tag[3].swap <= s2_swap;
      tag[3].x    <= x;
      tag[3].x2   <= '0;
      s3_x2p      <= 60'(x) * 60'(x);
    end
    if (en[4]) begin
      tag[4] <= {tag[3].quad, tag[3].swap, tag[3].x, x2};
      s4_pa  <= 62'(x2) * 62'(RECIP_42);
      s4_pb  <= 62'(x2) * 62'(RECIP_56);
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        tag[k] <= tag[k-1];
      end
    end
    if (en[5]) begin
      s5_ma <= 61'(tag[4].x2) * 61'(a1);
      s5_mb <= 61'(tag[4].x2) * 61'(b1);
    end
    if (en[6]) begin
      s6_ma <= m5a;
      s6_mb <= m5b;
      s6_pa <= 62'(m5a) * 62'(RECIP_20);
      s6_pb <= 62'(m5b) * 62'(RECIP_30);
    end
    if (en[7]) begin
      s7_ma <= 61'(tag[6].x2) * 61'(a2);
      s7_mb <= 61'(tag[6].x2) * 61'(b2);
    end
    if (en[8]) begin
      s8_ma <= m7a;
      s8_mb <= m7b;
      s8_pa <= 62'(m7a) * 62'(RECIP_6);
      s8_pb <= 62'(m7b) * 62'(RECIP_12);
    end
    if (en[9]) begin
      s9_ma <= 61'(tag[8].x) * 61'(a3);
      s9_mb <= 61'(tag[8].x2) * 61'(b3);
    end
  end

  // stage 10: fold back to the full circle
  logic [30:0] sb, cb;
  logic [29:0] m9b;
  logic signed [31:0] ssb, scb, sn, cs;

  always_comb begin
    sb  = 31'(s9_ma >> 30);
    m9b = 30'(s9_mb >> 30);
    cb  = Q30_ONE - 31'(m9b >> 1);
    ssb = tag[9].swap ? $signed({1'b0, cb}) : $signed({1'b0, sb});
    scb = tag[9].swap ? $signed({1'b0, sb}) : $signed({1'b0, cb});
    case (tag[9].quad)
      2'd0: begin
        sn = ssb;
        cs = scb;
      end
      2'd1: begin
        sn = scb;
        cs = -ssb;
      end
      2'd2: begin
        sn = -ssb;
        cs = -scb;
      end
      default: begin
        sn = -scb;
        cs = ssb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      cos_q     <= cs;
      sin_neg_q <= -sn;
    end
  end

endmodule

`default_nettype wire

[sv/rsq_corner.sv]
// Corner offset products and saturated vertex positions, output register.
`default_nettype none

module rsq_corner
  import rsq_pkg::*;
(
  input  logic               clk,
  input  stage_vec_t         en,
  input  side_t              side,
  input  logic signed [31:0] c,
  input  logic signed [31:0] s,
  output quad_t              quad
);

  localparam logic signed [65:0] HALF_Q31 = 66'sd1 <<< 30;
  localparam logic signed [66:0] MAX32    = 67'sd2147483647;
  localparam logic signed [66:0] MIN32    = -67'sd2147483648;

  function automatic logic signed [31:0] vert(input logic signed [65:0] t,
                                              input logic signed [51:0] ctr);
    logic signed [65:0] r;
    logic signed [66:0] sum;
    r   = (t + HALF_Q31) >>> 31;
    sum = 67'(r) + 67'(ctr);
    if (sum > MAX32) begin
      return 32'sh7FFF_FFFF;
    end else if (sum < MIN32) begin
      return 32'sh8000_0000;
    end
    return 32'(sum);
  endfunction

  logic signed [63:0] s11_p, s11_q;
  side_t s11_side;

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-2]) begin
      s11_p    <= $signed(64'(side.edge_size)) * 64'(c);
      s11_q    <= $signed(64'(side.edge_size)) * 64'(s);
      s11_side <= side;
    end
  end

  logic signed [65:0] p, q;
  assign p = 66'(s11_p);
  assign q = 66'(s11_q);

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      quad.bl_x       <= vert(q - p, s11_side.cx);
      quad.bl_y       <= vert(-q - p, s11_side.cy);
      quad.br_x       <= vert(p + q, s11_side.cx);
      quad.br_y       <= vert(q - p, s11_side.cy);
      quad.tl_x       <= vert(-p - q, s11_side.cx);
      quad.tl_y       <= vert(p - q, s11_side.cy);
      quad.tr_x       <= vert(p - q, s11_side.cx);
      quad.tr_y       <= vert(q + p, s11_side.cy);
      quad.color_rgba <= s11_side.color_rgba;
      quad.last_quad  <= s11_side.last;
    end
  end

endmodule

`default_nettype wire

[sv/rotated_sprite_quad_expansion_unit.sv]
// Rotated sprite quad expansion unit: one particle in, one rotated quad and color out.
//
// Particles arrive as beats on the particle channel and leave as quads on the
// quad channel, both valid/ready. Each quad carries four saturated s15.16
// vertices, the packed RGBA bytes and the frame-end flag of its particle.
// The configuration port writes one register per cycle at cfg_index while
// cfg_write is high; write it only while no particle is in flight.
// The path from the accepting edge to quad.valid has 13 register stages,
// set by the sine/cosine chain of multiply and reciprocal-divide stages.
// Throughput is one particle per cycle with no stall.
// Reset clears all stage valid bits and loads the default registers: free
// position mode, no premultiply, zero anchor and offset, identity matrix.
// When the receiver stalls, the output beat holds and stages fill their
// bubbles; particle.ready drops only when every stage holds a beat.
`default_nettype none

module rotated_sprite_quad_expansion_unit
  import rsq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rsq_stream_if.sink             particle,
  rsq_stream_if.source           quad
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_mode     <= MODE_FREE;
      cfg.premultiply_alpha <= 1'b0;
      cfg.anchor_x          <= '0;
      cfg.anchor_y          <= '0;
      cfg.offset_x          <= '0;
      cfg.offset_y          <= '0;
      cfg.m00               <= 32'sd1 <<< FRAC_BITS;
      cfg.m01               <= '0;
      cfg.m10               <= '0;
      cfg.m11               <= 32'sd1 <<< FRAC_BITS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POSITION_MODE:     cfg.position_mode     <= cfg_data[1:0];
        REG_PREMULTIPLY_ALPHA: cfg.premultiply_alpha <= cfg_data[0];
        REG_ANCHOR_X:          cfg.anchor_x          <= cfg_data[31:0];
        REG_ANCHOR_Y:          cfg.anchor_y          <= cfg_data[31:0];
        REG_OFFSET_X:          cfg.offset_x          <= cfg_data[31:0];
        REG_OFFSET_Y:          cfg.offset_y          <= cfg_data[31:0];
        REG_MATRIX_ROW_A: begin
          cfg.m00 <= cfg_data[31:0];
          cfg.m01 <= cfg_data[63:32];
        end
        REG_MATRIX_ROW_B: begin
          cfg.m10 <= cfg_data[31:0];
          cfg.m11 <= cfg_data[63:32];
        end
        default: ;
      endcase
    end
  end

  stage_vec_t         en;
  side_t              side;
  logic signed [31:0] cos_v, sin_neg_v;
  quad_t              quad_data;

  rsq_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (particle.valid),
    .in_ready  (particle.ready),
    .out_valid (quad.valid),
    .out_ready (quad.ready),
    .en        (en)
  );

  rsq_center u_center (
    .clk  (clk),
    .en   (en),
    .p    (particle.data),
    .cfg  (cfg),
    .side (side)
  );

  rsq_sincos u_sincos (
    .clk          (clk),
    .en           (en),
    .rotation_deg (particle.data.rotation_deg),
    .cos_q        (cos_v),
    .sin_neg_q    (sin_neg_v)
  );

  rsq_corner u_corner (
    .clk  (clk),
    .en   (en),
    .side (side),
    .c    (cos_v),
    .s    (sin_neg_v),
    .quad (quad_data)
  );

  assign quad.data = quad_data;

endmodule

`default_nettype wire
